>>> rtl/pkis_pkg.sv
// ----------------------------------------------------------------------------
// pkis_pkg
// Shared sizes, order codes and the controller/datapath handshake types of
// the paired key insertion sorter.
// ----------------------------------------------------------------------------
package pkis_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_WIDTH = 32;
  localparam int DATA_W    = 32;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  // keys are 32 bits on the wire, so wider compare widths add only sign bits
  localparam int CMP_W = (KEY_WIDTH < DATA_W) ? KEY_WIDTH : DATA_W;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  localparam logic [1:0] ORDER_ASC  = 2'd0;
  localparam logic [1:0] ORDER_DESC = 2'd1;

  typedef enum logic [1:0] {
    RD_I,
    RD_IM1,
    RD_JM2,
    RD_E
  } rd_src_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_SHIFT,
    WR_HOLD
  } wr_src_t;

  typedef struct packed {
    logic    load_en;
    logic    i_init;
    logic    i_inc;
    logic    hold_ld;
    logic    j_dec;
    logic    e_clr;
    logic    e_inc;
    logic    out_ld;
    logic    close_clr;
    rd_src_t rd_src;
    wr_src_t wr_src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_last;
    logic fill_nz;
    logic precedes;
    logic j_one;
    logic i_last;
    logic e_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/pkis_in_if.sv
// ----------------------------------------------------------------------------
// pkis_in_if
// Request channel carrying one key/payload pair and the load-closing flag.
// ----------------------------------------------------------------------------
interface pkis_in_if;
  import pkis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sort_key;
  logic signed [DATA_W-1:0] payload;
  logic                     load_last;

  modport source (output valid, output sort_key, output payload, output load_last,
                  input ready);
  modport sink   (input valid, input sort_key, input payload, input load_last,
                  output ready);
endinterface

>>> rtl/pkis_out_if.sv
// ----------------------------------------------------------------------------
// pkis_out_if
// Result channel carrying one sorted pair with burst-end and drop flags.
// ----------------------------------------------------------------------------
interface pkis_out_if;
  import pkis_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_key;
  logic signed [DATA_W-1:0] out_payload;
  logic                     out_last;
  logic                     overflowed;

  modport source (output valid, output out_key, output out_payload, output out_last,
                  output overflowed, input ready);
  modport sink   (input valid, input out_key, input out_payload, input out_last,
                  input overflowed, output ready);
endinterface

>>> rtl/pkis_dpath.sv
// ----------------------------------------------------------------------------
// pkis_dpath
// Pair memory, sort indexes, hold register, key comparator and output
// register of the sorter.
// ----------------------------------------------------------------------------
module pkis_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pkis_pkg::ctrl_cmd_t               cmd,
  output pkis_pkg::ctrl_sts_t               sts,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_data,
  input  logic signed [pkis_pkg::DATA_W-1:0] in_sort_key,
  input  logic signed [pkis_pkg::DATA_W-1:0] in_payload,
  input  logic                              in_load_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pkis_pkg::DATA_W-1:0] out_key,
  output logic signed [pkis_pkg::DATA_W-1:0] out_payload,
  output logic                              out_last,
  output logic                              out_overflowed
);
  import pkis_pkg::*;

  logic [DATA_W-1:0] key_mem [MAX_ITEMS];
  logic [DATA_W-1:0] pay_mem [MAX_ITEMS];

  logic [1:0]        sort_order_r;
  logic [CNT_W-1:0]  fill_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  j_r;
  logic [CNT_W-1:0]  e_r;
  logic [DATA_W-1:0] hold_key_r;
  logic [DATA_W-1:0] hold_pay_r;
  logic [DATA_W-1:0] rd_key_r;
  logic [DATA_W-1:0] rd_pay_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_key_r;
  logic [DATA_W-1:0] out_pay_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic [CNT_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_key;
  logic [DATA_W-1:0] wr_pay;
  logic              wr_en;
  logic              full;
  logic              out_fire;
  logic              precedes;
  logic [CNT_W-1:0]  n_m1;

  assign full     = (fill_r == MAX_CNT);
  assign out_fire = out_valid_r && out_ready;
  assign n_m1     = fill_r - CNT_W'(1);

  always_comb begin
    case (cmd.rd_src)
      RD_I:    rd_addr = i_r;
      RD_IM1:  rd_addr = i_r - CNT_W'(1);
      RD_JM2:  rd_addr = j_r - CNT_W'(2);
      default: rd_addr = e_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_r;
    wr_key  = rd_key_r;
    wr_pay  = rd_pay_r;
    case (cmd.wr_src)
      WR_LOAD: begin
        wr_en   = !full;
        wr_addr = fill_r;
        wr_key  = in_sort_key;
        wr_pay  = in_payload;
      end
      WR_SHIFT: wr_en = 1'b1;
      WR_HOLD: begin
        wr_en  = 1'b1;
        wr_key = hold_key_r;
        wr_pay = hold_pay_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // true when the held key must move ahead of the one just read
  always_comb begin
    case (sort_order_r)
      ORDER_ASC:  precedes = $signed(hold_key_r[CMP_W-1:0]) < $signed(rd_key_r[CMP_W-1:0]);
      ORDER_DESC: precedes = $signed(hold_key_r[CMP_W-1:0]) > $signed(rd_key_r[CMP_W-1:0]);
      default:    precedes = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr[IDX_W-1:0]] <= wr_key;
      pay_mem[wr_addr[IDX_W-1:0]] <= wr_pay;
    end
    rd_key_r <= key_mem[rd_addr[IDX_W-1:0]];
    rd_pay_r <= pay_mem[rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_order_r <= ORDER_ASC;
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      e_r          <= '0;
    end else begin
      if (cfg_we) begin
        sort_order_r <= cfg_data;
      end
      if (cmd.load_en) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
      if (cmd.close_clr) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end
      if (cmd.i_init) begin
        i_r <= CNT_W'(1);
      end else if (cmd.i_inc) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.hold_ld) begin
        j_r <= i_r;
      end else if (cmd.j_dec) begin
        j_r <= j_r - CNT_W'(1);
      end
      if (cmd.e_clr) begin
        e_r <= '0;
      end else if (cmd.e_inc) begin
        e_r <= e_r + CNT_W'(1);
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_ld) begin
      hold_key_r <= rd_key_r;
      hold_pay_r <= rd_pay_r;
    end
    if (cmd.out_ld) begin
      out_key_r  <= rd_key_r;
      out_pay_r  <= rd_pay_r;
      out_last_r <= (e_r == n_m1);
      out_ovf_r  <= ovf_r;
    end
  end

  always_comb begin
    sts.in_last  = in_load_last;
    sts.fill_nz  = (fill_r != '0);
    sts.precedes = precedes;
    sts.j_one    = (j_r == CNT_W'(1));
    sts.i_last   = (i_r == n_m1);
    sts.e_last   = (e_r == n_m1);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_key        = out_key_r;
  assign out_payload    = out_pay_r;
  assign out_last       = out_last_r;
  assign out_overflowed = out_ovf_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_CNT)
    else $error("fill count beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while a result is pending");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_ld && cmd.close_clr) |=> (fill_r == '0 && !ovf_r && out_last_r))
    else $error("burst end did not close the load");

  a_shift_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_src == WR_SHIFT) |-> (j_r != '0 && j_r <= i_r && i_r < fill_r))
    else $error("shift write outside the sorted prefix");

endmodule

>>> rtl/pkis_ctrl.sv
// ----------------------------------------------------------------------------
// pkis_ctrl
// Sequencer for load, in-memory insertion sort and result emission.
// ----------------------------------------------------------------------------
module pkis_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pkis_pkg::ctrl_sts_t sts,
  output pkis_pkg::ctrl_cmd_t cmd
);
  import pkis_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SRD,
    ST_SHOLD,
    ST_SCMP,
    ST_SPUT,
    ST_ERD,
    ST_ECAP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_LOAD);

  always_comb begin
    cmd        = '0;
    cmd.rd_src = RD_E;
    cmd.wr_src = WR_NONE;
    state_nxt  = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load_en = 1'b1;
          cmd.wr_src  = WR_LOAD;
          if (sts.in_last) begin
            // a single stored pair needs no sorting pass
            if (sts.fill_nz) begin
              cmd.i_init = 1'b1;
              state_nxt  = ST_SRD;
            end else begin
              cmd.e_clr = 1'b1;
              state_nxt = ST_ERD;
            end
          end
        end
      end
      ST_SRD: begin
        cmd.rd_src = RD_I;
        state_nxt  = ST_SHOLD;
      end
      ST_SHOLD: begin
        cmd.hold_ld = 1'b1;
        cmd.rd_src  = RD_IM1;
        state_nxt   = ST_SCMP;
      end
      ST_SCMP: begin
        cmd.rd_src = RD_JM2;
        if (sts.precedes) begin
          // shift the earlier pair up one slot and keep walking down
          cmd.wr_src = WR_SHIFT;
          cmd.j_dec  = 1'b1;
          if (sts.j_one) begin
            state_nxt = ST_SPUT;
          end
        end else begin
          state_nxt = ST_SPUT;
        end
      end
      ST_SPUT: begin
        cmd.wr_src = WR_HOLD;
        cmd.i_inc  = 1'b1;
        if (sts.i_last) begin
          cmd.e_clr = 1'b1;
          state_nxt = ST_ERD;
        end else begin
          state_nxt = ST_SRD;
        end
      end
      ST_ERD: begin
        // keep re-reading until the output register can take the pair
        cmd.rd_src = RD_E;
        if (sts.out_free) begin
          state_nxt = ST_ECAP;
        end
      end
      ST_ECAP: begin
        cmd.out_ld = 1'b1;
        cmd.e_inc  = 1'b1;
        if (sts.e_last) begin
          cmd.close_clr = 1'b1;
          state_nxt     = ST_LOAD;
        end else begin
          state_nxt = ST_ERD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/paired_key_insertion_sort.sv
// ----------------------------------------------------------------------------
// paired_key_insertion_sort
// Stores key/payload pairs, insertion-sorts them in memory when the load
// closes, and streams them out in the configured key order.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        sort_key, payload, load_last
//   out_ch    out   valid/ready        out_key, out_payload, out_last, overflowed
//   cfg       in    cfg_we (no wait)   cfg_data = sort_order
//
// Loading takes one request per cycle. After the closing request the pair
// memory (one write, one registered read port) is sorted in place: each pair
// i is read and held, walks down past each earlier pair that it precedes,
// which shifts up one slot, and is then written into the slot left free.
// Emission then reads each result and loads it into the output register.
// Requests are refused during sort and emission. Reset clears the fill
// count, the drop flag and the order register; the memory needs no clearing
// pass. A stalled sink holds the output register and the emission walk.
// ----------------------------------------------------------------------------
module paired_key_insertion_sort (
  input  logic       clk,
  input  logic       rst_n,
  pkis_in_if.sink    in_ch,
  pkis_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);
  import pkis_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  pkis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pkis_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_sort_key    (in_ch.sort_key),
    .in_payload     (in_ch.payload),
    .in_load_last   (in_ch.load_last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_key        (out_ch.out_key),
    .out_payload    (out_ch.out_payload),
    .out_last       (out_ch.out_last),
    .out_overflowed (out_ch.overflowed)
  );

  assign in_ch.ready = in_ready;

endmodule

>>> test/tb_paired_key_insertion_sort.sv
// ----------------------------------------------------------------------------
// tb_paired_key_insertion_sort
// Loads key/payload lists with random gaps and stalls, predicts each sorted
// burst with a stable insertion sort, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_paired_key_insertion_sort;
  timeunit 1ns;
  timeprecision 1ps;

  import pkis_pkg::*;

  localparam logic [1:0] ORDER_KEEP  = 2'd2;
  localparam logic [1:0] ORDER_SPARE = 2'd3;  // undefined code, behaves as keep

  localparam int RANDOM_ITEMS  = 500;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;

  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] payload;
    logic                     last;
    logic                     overflowed;
  } sorted_pair_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_data;

  pkis_in_if  in_ch ();
  pkis_out_if out_ch ();

  paired_key_insertion_sort DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic signed [DATA_W-1:0] held_keys[$];
  logic signed [DATA_W-1:0] held_payloads[$];
  logic                     dropped_pair;
  logic [1:0]               order_mode;
  sorted_pair_t             sorted_q[$];

  int  mismatches;
  int  items_sent;
  bit  no_idle;
  int  sink_hold;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Incoming key moves ahead of the earlier one only on a strict compare,
  // which keeps equal keys in load order.
  function automatic bit key_precedes(logic signed [DATA_W-1:0] incoming,
                                      logic signed [DATA_W-1:0] earlier,
                                      logic [1:0] mode);
    logic signed [CMP_W-1:0] a;
    logic signed [CMP_W-1:0] b;
    a = incoming[CMP_W-1:0];
    b = earlier[CMP_W-1:0];
    if (mode == ORDER_ASC) return a < b;
    if (mode == ORDER_DESC) return a > b;
    return 1'b0;
  endfunction

  function automatic void predict_pair(logic signed [DATA_W-1:0] key,
                                       logic signed [DATA_W-1:0] payload,
                                       logic last);
    logic signed [DATA_W-1:0] keys[MAX_ITEMS];
    logic signed [DATA_W-1:0] pays[MAX_ITEMS];
    sorted_pair_t             res;
    int                       n;
    int                       j;
    if (held_keys.size() < MAX_ITEMS) begin
      held_keys     = {held_keys, key};
      held_payloads = {held_payloads, payload};
    end else begin
      dropped_pair = 1'b1;
    end
    if (!last) return;
    n = held_keys.size();
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && key_precedes(held_keys[i], keys[j-1], order_mode)) begin
        keys[j] = keys[j-1];
        pays[j] = pays[j-1];
        j--;
      end
      keys[j] = held_keys[i];
      pays[j] = held_payloads[i];
    end
    for (int i = 0; i < n; i++) begin
      res.key        = keys[i];
      res.payload    = pays[i];
      res.last       = (i == n - 1);
      res.overflowed = dropped_pair;
      sorted_q = {sorted_q, res};
    end
    held_keys.delete();
    held_payloads.delete();
    dropped_pair = 1'b0;
  endfunction

  task automatic send_pair(logic signed [DATA_W-1:0] key,
                           logic signed [DATA_W-1:0] payload,
                           logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sort_key  <= key;
    in_ch.payload   <= payload;
    in_ch.load_last <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_pair(key, payload, last);
    items_sent++;
  endtask

  // Hold the request side until every predicted result has come out.
  task automatic wait_sorted_drained();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (sorted_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sorted_q.size() != 0) begin
      $display("%0d sorted results never arrived", sorted_q.size());
      mismatches++;
      sorted_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(logic [1:0] mode);
    wait_sorted_drained();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_mode = mode;
  endtask

  function automatic logic signed [DATA_W-1:0] draw_key(bit narrow);
    case ($urandom_range(0, 7))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return '0;
      3: return -1;
      default: begin
        if (narrow) return $urandom_range(0, 6) - 3;
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_list(int len, bit narrow);
    for (int i = 0; i < len; i++)
      send_pair(draw_key(narrow), $urandom, i == len - 1);
  endtask

  // extremes of key and payload, equal keys, a single-pair list
  task automatic test_extremes();
    write_order(ORDER_ASC);
    send_pair(KEY_MAX,  KEY_MIN, 1'b0);
    send_pair(KEY_MIN,  KEY_MAX, 1'b0);
    send_pair(0,        -1,      1'b0);
    send_pair(-1,       0,       1'b0);
    send_pair(KEY_MAX,  1,       1'b0);
    send_pair(KEY_MIN,  2,       1'b0);
    send_pair(1,        3,       1'b0);
    send_pair(-1,       4,       1'b1);
    send_pair(KEY_MIN,  KEY_MAX, 1'b1);
  endtask

  // every order code, each written in the middle of a load
  task automatic test_each_order();
    logic [1:0] modes[4];
    modes = '{ORDER_DESC, ORDER_KEEP, ORDER_SPARE, ORDER_ASC};
    foreach (modes[m]) begin
      send_pair(5,       $urandom, 1'b0);
      send_pair(-7,      $urandom, 1'b0);
      write_order(modes[m]);
      send_pair(5,       $urandom, 1'b0);
      send_pair(KEY_MAX, $urandom, 1'b1);
    end
  endtask

  // exactly full, then past capacity with the closing request dropped
  task automatic test_capacity();
    write_order(2'($urandom_range(0, 3)));
    send_list(MAX_ITEMS, 1'b1);
    send_list(MAX_ITEMS + 2, 1'b1);
    send_list(MAX_ITEMS + 1, 1'b0);
  endtask

  // long sink stall with requests still offered, then a full drain
  task automatic test_output_stall();
    no_idle = 1'b1;
    sink_hold = LONG_HOLD;
    for (int l = 0; l < 3; l++) send_list(6, 1'b1);
    no_idle = 1'b0;
    wait_sorted_drained();
  endtask

  task automatic test_random_lists();
    int len;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) write_order(2'($urandom_range(0, 3)));
      no_idle = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 4)
                                        : $urandom_range(1, 12);
      send_list(len, $urandom_range(0, 1));
    end
    no_idle = 1'b0;
  endtask

  // result sink: random stall before each result, plus the long hold on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && sink_hold == 0);
    end
  end

  task automatic report_field(string name, logic signed [DATA_W-1:0] want,
                              logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d actual %0d at %0t", name, want, got, $realtime);
    end
  endtask

  initial begin : result_checker
    sorted_pair_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (sorted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result key %0d at %0t", out_ch.out_key, $realtime);
        end else begin
          want = sorted_q.pop_front();
          report_field("key",        want.key,        out_ch.out_key);
          report_field("payload",    want.payload,    out_ch.out_payload);
          report_field("last",       DATA_W'(want.last), DATA_W'(out_ch.out_last));
          report_field("overflowed", DATA_W'(want.overflowed), DATA_W'(out_ch.overflowed));
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.sort_key  <= '0;
    in_ch.payload   <= '0;
    in_ch.load_last <= 1'b0;
    order_mode   = ORDER_ASC;
    dropped_pair = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    no_idle      = 1'b0;
    sink_hold    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_each_order();
    test_capacity();
    test_output_stall();
    test_random_lists();
    wait_sorted_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> paired_key_insertion_sort.f
rtl/pkis_pkg.sv
rtl/pkis_in_if.sv
rtl/pkis_out_if.sv
rtl/pkis_dpath.sv
rtl/pkis_ctrl.sv
rtl/paired_key_insertion_sort.sv
test/tb_paired_key_insertion_sort.sv
